/* hw/rtl/evr_pkg.sv */
// Shared codes, widths and the cosine table entry function for the eased value ramp.
`default_nettype none
package evr_pkg;

    localparam int CMD_W    = 2;
    localparam int ELAP_W   = 16;
    localparam int FIELD_W  = 24;
    localparam int PROG_W   = 17;
    localparam int CNT_W    = 24;
    localparam int MODE_W   = 3;
    localparam int IDX_W    = 2;
    localparam int DIVN_W   = 32;
    localparam int RAD_W    = 34;
    localparam int ROOT_W   = 17;
    localparam int MULB_W   = 17;

    localparam logic [PROG_W-1:0] ONE_Q16 = 17'h10000;
    localparam logic [CNT_W-1:0]  CNT_MAX = 24'hFFFFFF;
    localparam longint ONE_Q30 = 64'd1073741824;
    localparam longint PI_Q30  = 64'd3373259426;

    localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ANIM = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SET  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP  = 2'd3;

    localparam logic [MODE_W-1:0] MODE_JUMP     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_LINEAR   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_QUAD     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ROOT     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_COS      = 3'd4;
    localparam logic [MODE_W-1:0] MODE_RESERVED = 3'd7;

    localparam logic [IDX_W-1:0] REG_MODE     = 2'd0;
    localparam logic [IDX_W-1:0] REG_DURATION = 2'd1;
    localparam logic [IDX_W-1:0] REG_DELAY    = 2'd2;

    // Q16 value of (1 - cos x) / 2 from the cosine series through the x^14 term, x in Q30 radians.
    function automatic logic [PROG_W-1:0] half_cos_q16(input longint x);
        longint x2;
        longint term;
        longint sum;
        longint res;
        x2 = (x * x) >>> 30;
        term = ONE_Q30;
        sum = ONE_Q30;
        for (int n = 1; n <= 7; n++)
        begin
            term = (term * x2) >>> 30;
            case (n)
                1: term = term / 2;
                2: term = term / 12;
                3: term = term / 30;
                4: term = term / 56;
                5: term = term / 90;
                6: term = term / 132;
                default: term = term / 182;
            endcase
            if ((n % 2) == 1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        if (sum < 0)
            sum = 0;
        if (sum > ONE_Q30)
            sum = ONE_Q30;
        res = ((ONE_Q30 - sum) + 16384) >>> 15;
        return res[PROG_W-1:0];
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/evr_cos_rom.sv */
// Constant cosine easing table with a registered read port.
`default_nettype none
module evr_cos_rom #(
    parameter int DEPTH = 256
) (
    input  wire logic                                clk,
    input  wire logic [$clog2(DEPTH+1)-1:0]          addr,
    output logic      [evr_pkg::PROG_W-1:0]          data
);
    localparam int AW = $clog2(DEPTH + 1);
    localparam int SLOTS = 1 << AW;

    logic [evr_pkg::PROG_W-1:0] tab [SLOTS];

    for (genvar k = 0; k < SLOTS; k++)
    begin : g_entry
        localparam int KK = (2 * k <= DEPTH) ? k : DEPTH - k;
        localparam longint XV = (evr_pkg::PI_Q30 * KK) / DEPTH;
        localparam logic [evr_pkg::PROG_W-1:0] HC = evr_pkg::half_cos_q16(XV);
        // The upper half mirrors the lower half about one half.
        localparam logic [evr_pkg::PROG_W-1:0] V =
            (k > DEPTH) ? '0 : ((2 * k <= DEPTH) ? HC : evr_pkg::ONE_Q16 - HC);
        assign tab[k] = V;
    end

    always_ff @(posedge clk)
    begin
        data <= tab[addr];
    end
endmodule
`default_nettype wire

/* hw/rtl/evr_serial_div.sv */
// Bit-serial restoring divider for the progress step, one quotient bit per cycle.
`default_nettype none
module evr_serial_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          go,
    input  wire logic [evr_pkg::DIVN_W-1:0]    dividend,
    input  wire logic [evr_pkg::CNT_W-1:0]     divisor,
    output logic      [evr_pkg::PROG_W-1:0]    quotient,
    output logic                               overflow,
    output logic                               done
);
    logic [evr_pkg::DIVN_W-1:0] num_reg;
    logic [evr_pkg::CNT_W-1:0]  den_reg;
    logic [evr_pkg::CNT_W-1:0]  rem_reg;
    logic [evr_pkg::PROG_W-1:0] q_reg;
    logic                       ovf_reg;
    logic [4:0]                 cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [evr_pkg::CNT_W:0]    trial;
    logic                       fits;

    assign trial = {rem_reg, num_reg[evr_pkg::DIVN_W-1]};
    assign fits = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= '0;
                num_reg <= dividend;
                den_reg <= divisor;
                rem_reg <= '0;
                q_reg <= '0;
                ovf_reg <= 1'b0;
            end
            else if (busy_reg)
            begin
                if (fits)
                    rem_reg <= evr_pkg::CNT_W'(trial - {1'b0, den_reg});
                else
                    rem_reg <= trial[evr_pkg::CNT_W-1:0];
                // Anything pushed past bit 16 means the ramp is complete anyway.
                q_reg <= {q_reg[evr_pkg::PROG_W-2:0], fits};
                ovf_reg <= ovf_reg | q_reg[evr_pkg::PROG_W-1];
                num_reg <= {num_reg[evr_pkg::DIVN_W-2:0], 1'b0};
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(evr_pkg::DIVN_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient = q_reg;
    assign overflow = ovf_reg;
    assign done = done_reg;
endmodule
`default_nettype wire

/* hw/rtl/evr_serial_sqrt.sv */
// Digit-serial integer square root, two radicand bits and one root bit per cycle.
`default_nettype none
module evr_serial_sqrt (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          go,
    input  wire logic [evr_pkg::RAD_W-1:0]     radicand,
    output logic      [evr_pkg::ROOT_W-1:0]    root,
    output logic                               done
);
    localparam int REM_W = evr_pkg::ROOT_W + 2;

    logic [evr_pkg::RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]           rem_reg;
    logic [evr_pkg::ROOT_W-1:0] root_reg;
    logic [4:0]                 cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [REM_W-1:0]           cand;
    logic [REM_W-1:0]           trial;
    logic                       fits;

    assign cand = {rem_reg[REM_W-3:0], rad_reg[evr_pkg::RAD_W-1 -: 2]};
    assign trial = {root_reg, 2'b01};
    assign fits = cand >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= '0;
                rad_reg <= radicand;
                rem_reg <= '0;
                root_reg <= '0;
            end
            else if (busy_reg)
            begin
                rem_reg <= fits ? cand - trial : cand;
                root_reg <= {root_reg[evr_pkg::ROOT_W-2:0], fits};
                rad_reg <= {rad_reg[evr_pkg::RAD_W-3:0], 2'b00};
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(evr_pkg::ROOT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign root = root_reg;
    assign done = done_reg;
endmodule
`default_nettype wire

/* hw/rtl/evr_serial_mul.sv */
// Shift-add multiplier: signed multiplicand times 17-bit unsigned multiplier, a bit per cycle.
`default_nettype none
module evr_serial_mul #(
    parameter int MW = 25
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               go,
    input  wire logic signed [MW-1:0]               a,
    input  wire logic [evr_pkg::MULB_W-1:0]         b,
    output logic      [MW+evr_pkg::MULB_W-1:0]      product,
    output logic                                    done
);
    localparam int PW = MW + evr_pkg::MULB_W;

    logic [PW-1:0]              acc_reg;
    logic [PW-1:0]              ash_reg;
    logic [evr_pkg::MULB_W-1:0] bsh_reg;
    logic [4:0]                 cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= '0;
                acc_reg <= '0;
                ash_reg <= PW'(a);
                bsh_reg <= b;
            end
            else if (busy_reg)
            begin
                if (bsh_reg[0])
                    acc_reg <= acc_reg + ash_reg;
                ash_reg <= {ash_reg[PW-2:0], 1'b0};
                bsh_reg <= {1'b0, bsh_reg[evr_pkg::MULB_W-1:1]};
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(evr_pkg::MULB_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign product = acc_reg;
    assign done = done_reg;
endmodule
`default_nettype wire

/* hw/rtl/eased_value_ramp_unit.sv */
// Top level of the eased value ramp: command sequencer, ramp state and result register.
// Usage: each request on the input channel (cmd, elapsed, target) yields exactly one
// result on the output channel (current_value, progress_out, changed, started, arrived).
// Animate-to, reset-to, unused commands, jump-mode ticks, ticks still in the start
// delay and ticks with zero duration finish in the accepting cycle; the result is
// registered and shows in the next cycle. A tick that advances the ramp runs a
// bit-serial divider for the progress step; unless that step completes the ramp, it
// then runs the easing unit (serial multiplier for the quadratic curve, serial square
// root for one-minus-root, 2 table reads and a serial multiply for cosine) and then a
// serial multiply for interpolation. The block works on one request at a time.
// A new request is taken only while the sequencer is idle and the result register is
// empty or being emptied in that cycle, so a stalled receiver holds off new requests.
// Configuration writes take effect at once and are meant for an idle block; writing
// the delay register restarts the delay timer.
// Reset gives linear easing, 150000 microsecond duration, no delay, value zero and a
// completed ramp.
`default_nettype none
module eased_value_ramp_unit #(
    parameter int VALUE_WIDTH      = 24,
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [evr_pkg::CMD_W-1:0]          cmd,
    input  wire logic [evr_pkg::ELAP_W-1:0]         elapsed,
    input  wire logic signed [evr_pkg::FIELD_W-1:0] target,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic signed [evr_pkg::FIELD_W-1:0]      current_value,
    output logic [evr_pkg::PROG_W-1:0]              progress_out,
    output logic                                    changed,
    output logic                                    started,
    output logic                                    arrived,
    input  wire logic                               cfg_we,
    input  wire logic [evr_pkg::IDX_W-1:0]          cfg_index,
    input  wire logic [evr_pkg::CNT_W-1:0]          cfg_data
);
    localparam int VW = VALUE_WIDTH;
    localparam int MW = (VW + 1 > 18) ? VW + 1 : 18;
    localparam int PW = MW + evr_pkg::MULB_W;
    localparam int AW = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int POSW = evr_pkg::PROG_W + AW;
    localparam int PW_ = evr_pkg::PROG_W;

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_QUAD, S_SQRT, S_ROM_LO, S_ROM_HI, S_ROM_WAIT, S_INTERP, S_LERP
    } state_t;

    state_t state_reg;

    logic [evr_pkg::MODE_W-1:0] mode_reg;
    logic [evr_pkg::CNT_W-1:0]  dur_reg;
    logic [evr_pkg::CNT_W-1:0]  dly_reg;
    logic [evr_pkg::CNT_W-1:0]  dly_el_reg;
    logic signed [VW-1:0]       value_reg;
    logic signed [VW-1:0]       start_val_reg;
    logic signed [VW-1:0]       goal_reg;
    logic [PW_-1:0]             prog_reg;
    logic [evr_pkg::ELAP_W-1:0] elap_reg;
    logic                       out_valid_reg;
    logic                       chg_reg;
    logic                       st_reg;
    logic                       arr_reg;

    logic                       div_go_reg;
    logic                       sqrt_go_reg;
    logic                       mul_go_reg;
    logic signed [MW-1:0]       mul_a_reg;
    logic [evr_pkg::MULB_W-1:0] mul_b_reg;
    logic [evr_pkg::RAD_W-1:0]  rad_reg;
    logic [AW-1:0]              rom_addr_reg;
    logic [AW-1:0]              idx_reg;
    logic [15:0]                frac_reg;
    logic [PW_-1:0]             lo_reg;

    logic [PW_-1:0]             div_q;
    logic                       div_ovf;
    logic                       div_done;
    logic [evr_pkg::ROOT_W-1:0] sqrt_root;
    logic                       sqrt_done;
    logic [PW-1:0]              mul_p;
    logic                       mul_done;
    logic [PW_-1:0]             rom_data;

    logic signed [VW-1:0]       tgt_v;
    logic                       accept;
    logic                       value_ne_goal;
    logic [PW_:0]               psum;
    logic                       ramp_done;
    logic [PW_-1:0]             p_new;
    logic [evr_pkg::CNT_W:0]    dly_sum;
    logic [PW-1:0]              prod_rnd;
    logic [PW_-1:0]             prod_q16;
    logic [POSW-1:0]            pos;
    logic signed [MW-1:0]       span;
    logic [PW_:0]               root_gap;

    if (VW >= evr_pkg::FIELD_W)
    begin : g_wide
        assign tgt_v = VW'(target);
        assign current_value = value_reg[evr_pkg::FIELD_W-1:0];
    end
    else
    begin : g_narrow
        assign tgt_v = target[VW-1:0];
        assign current_value = evr_pkg::FIELD_W'(value_reg);
    end

    assign accept = in_valid && in_ready;
    assign value_ne_goal = value_reg != goal_reg;
    assign psum = {1'b0, prog_reg} + {1'b0, div_q};
    assign ramp_done = div_ovf || psum[PW_] || psum[PW_-1];
    assign p_new = psum[PW_-1:0];
    assign dly_sum = {1'b0, dly_el_reg} + (evr_pkg::CNT_W+1)'(elapsed);
    assign prod_rnd = mul_p + PW'(32768);
    assign prod_q16 = prod_rnd[16 +: PW_];
    assign pos = POSW'(p_new) * POSW'(SINE_TABLE_DEPTH);
    assign span = MW'($signed({goal_reg[VW-1], goal_reg} - {start_val_reg[VW-1], start_val_reg}));
    assign root_gap = {1'b0, evr_pkg::ONE_Q16} - {1'b0, p_new};

    evr_serial_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go_reg),
        .dividend ({elap_reg, 16'h0000}),
        .divisor  (dur_reg),
        .quotient (div_q),
        .overflow (div_ovf),
        .done     (div_done)
    );

    evr_serial_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (sqrt_go_reg),
        .radicand (rad_reg),
        .root     (sqrt_root),
        .done     (sqrt_done)
    );

    evr_serial_mul #(
        .MW (MW)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (mul_go_reg),
        .a       (mul_a_reg),
        .b       (mul_b_reg),
        .product (mul_p),
        .done    (mul_done)
    );

    evr_cos_rom #(
        .DEPTH (SINE_TABLE_DEPTH)
    ) u_rom (
        .clk  (clk),
        .addr (rom_addr_reg),
        .data (rom_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mode_reg <= evr_pkg::MODE_LINEAR;
            dur_reg <= 24'd150000;
            dly_reg <= '0;
            dly_el_reg <= '0;
            value_reg <= '0;
            start_val_reg <= '0;
            goal_reg <= '0;
            prog_reg <= evr_pkg::ONE_Q16;
            out_valid_reg <= 1'b0;
            chg_reg <= 1'b0;
            st_reg <= 1'b0;
            arr_reg <= 1'b0;
            div_go_reg <= 1'b0;
            sqrt_go_reg <= 1'b0;
            mul_go_reg <= 1'b0;
        end
        else
        begin
            div_go_reg <= 1'b0;
            sqrt_go_reg <= 1'b0;
            mul_go_reg <= 1'b0;
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            if (cfg_we)
            begin
                case (cfg_index)
                    evr_pkg::REG_MODE: mode_reg <= cfg_data[evr_pkg::MODE_W-1:0];
                    evr_pkg::REG_DURATION: dur_reg <= cfg_data;
                    evr_pkg::REG_DELAY:
                    begin
                        dly_reg <= cfg_data;
                        dly_el_reg <= '0;
                    end
                    default: ;
                endcase
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        out_valid_reg <= 1'b1;
                        chg_reg <= 1'b0;
                        st_reg <= 1'b0;
                        arr_reg <= 1'b0;
                        case (cmd)
                            evr_pkg::CMD_TICK:
                            begin
                                if (mode_reg == evr_pkg::MODE_JUMP)
                                begin
                                    if (value_ne_goal)
                                    begin
                                        value_reg <= goal_reg;
                                        chg_reg <= 1'b1;
                                        arr_reg <= 1'b1;
                                    end
                                end
                                else if (dly_el_reg < dly_reg)
                                begin
                                    dly_el_reg <= dly_sum[evr_pkg::CNT_W] ? evr_pkg::CNT_MAX
                                                  : dly_sum[evr_pkg::CNT_W-1:0];
                                end
                                else if (dur_reg == '0)
                                begin
                                    prog_reg <= evr_pkg::ONE_Q16;
                                    if (value_ne_goal)
                                    begin
                                        value_reg <= goal_reg;
                                        chg_reg <= 1'b1;
                                        arr_reg <= 1'b1;
                                    end
                                end
                                else
                                begin
                                    // The result is held back until the ramp math is done.
                                    out_valid_reg <= 1'b0;
                                    elap_reg <= elapsed;
                                    div_go_reg <= 1'b1;
                                    state_reg <= S_DIV;
                                end
                            end
                            evr_pkg::CMD_ANIM:
                            begin
                                if (tgt_v != goal_reg)
                                begin
                                    start_val_reg <= value_reg;
                                    goal_reg <= tgt_v;
                                    prog_reg <= '0;
                                    dly_el_reg <= '0;
                                    st_reg <= 1'b1;
                                end
                            end
                            evr_pkg::CMD_SET:
                            begin
                                chg_reg <= value_reg != tgt_v;
                                value_reg <= tgt_v;
                                start_val_reg <= tgt_v;
                                goal_reg <= tgt_v;
                                prog_reg <= evr_pkg::ONE_Q16;
                                dly_el_reg <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        if (ramp_done)
                        begin
                            prog_reg <= evr_pkg::ONE_Q16;
                            out_valid_reg <= 1'b1;
                            chg_reg <= value_ne_goal;
                            arr_reg <= value_ne_goal;
                            st_reg <= 1'b0;
                            value_reg <= goal_reg;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            prog_reg <= p_new;
                            case (mode_reg)
                                evr_pkg::MODE_QUAD:
                                begin
                                    mul_a_reg <= MW'(p_new);
                                    mul_b_reg <= p_new;
                                    mul_go_reg <= 1'b1;
                                    state_reg <= S_QUAD;
                                end
                                evr_pkg::MODE_ROOT:
                                begin
                                    rad_reg <= {1'b0, root_gap[PW_-1:0], 16'h0000};
                                    sqrt_go_reg <= 1'b1;
                                    state_reg <= S_SQRT;
                                end
                                evr_pkg::MODE_COS:
                                begin
                                    idx_reg <= pos[16 +: AW];
                                    frac_reg <= pos[15:0];
                                    rom_addr_reg <= pos[16 +: AW];
                                    state_reg <= S_ROM_LO;
                                end
                                default:
                                begin
                                    mul_a_reg <= span;
                                    mul_b_reg <= p_new;
                                    mul_go_reg <= 1'b1;
                                    state_reg <= S_LERP;
                                end
                            endcase
                        end
                    end
                end
                S_QUAD:
                begin
                    if (mul_done)
                    begin
                        mul_a_reg <= span;
                        mul_b_reg <= prod_q16;
                        mul_go_reg <= 1'b1;
                        state_reg <= S_LERP;
                    end
                end
                S_SQRT:
                begin
                    if (sqrt_done)
                    begin
                        mul_a_reg <= span;
                        mul_b_reg <= evr_pkg::ONE_Q16 - sqrt_root;
                        mul_go_reg <= 1'b1;
                        state_reg <= S_LERP;
                    end
                end
                S_ROM_LO:
                begin
                    rom_addr_reg <= idx_reg + AW'(1);
                    state_reg <= S_ROM_HI;
                end
                S_ROM_HI:
                begin
                    lo_reg <= rom_data;
                    state_reg <= S_ROM_WAIT;
                end
                S_ROM_WAIT:
                begin
                    mul_a_reg <= MW'($signed({1'b0, rom_data} - {1'b0, lo_reg}));
                    mul_b_reg <= {1'b0, frac_reg};
                    mul_go_reg <= 1'b1;
                    state_reg <= S_INTERP;
                end
                S_INTERP:
                begin
                    if (mul_done)
                    begin
                        mul_a_reg <= span;
                        mul_b_reg <= lo_reg + prod_q16;
                        mul_go_reg <= 1'b1;
                        state_reg <= S_LERP;
                    end
                end
                S_LERP:
                begin
                    if (mul_done)
                    begin
                        value_reg <= start_val_reg + prod_rnd[16 +: VW];
                        out_valid_reg <= 1'b1;
                        chg_reg <= 1'b1;
                        st_reg <= 1'b0;
                        arr_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign progress_out = prog_reg;
    assign changed = chg_reg;
    assign started = st_reg;
    assign arrived = arr_reg;
endmodule
`default_nettype wire
